// ===== rtl/core/svpm_pkg.sv =====
// ============================================================================
// svpm_pkg
// Shared types and constants of the scan voltage to position map.
// ============================================================================
`default_nettype none

package svpm_pkg;

    localparam int VOLT_W     = 16;
    localparam int TRIG_W     = 16;
    localparam int COEF_W     = 32;
    localparam int POS_W      = 32;
    localparam int RAD_W      = 16;
    localparam int SQ_W       = 32;
    localparam int PROD_W     = 32;
    localparam int ROT_W      = 33;
    localparam int ROT_BITS   = 15;
    localparam int LO_W       = 24;
    localparam int CLAMP_SHIFT = 40;
    localparam int CLAMP_W    = 42;
    localparam int ROOT_STAGES = 4;
    localparam int ROOT_STEPS  = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COS_RHO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_RHO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd7;

    localparam logic signed [TRIG_W-1:0] COS_RHO_RESET = 16'sd32767;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
        logic signed [COEF_W-1:0] coef_d;
        logic signed [TRIG_W-1:0] cos_rho;
        logic signed [TRIG_W-1:0] sin_rho;
        logic signed [POS_W-1:0]  offset_x;
        logic signed [POS_W-1:0]  offset_y;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/svpm_cfg_regs.sv =====
// ============================================================================
// svpm_cfg_regs
// Calibration register file, written one word at a time over the config port.
// ============================================================================
`default_nettype none

module svpm_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [svpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [svpm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output svpm_pkg::cfg_t                        cfg
);

    svpm_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef_a   <= '0;
            cfg_reg.coef_b   <= '0;
            cfg_reg.coef_c   <= '0;
            cfg_reg.coef_d   <= '0;
            cfg_reg.cos_rho  <= svpm_pkg::COS_RHO_RESET;
            cfg_reg.sin_rho  <= '0;
            cfg_reg.offset_x <= '0;
            cfg_reg.offset_y <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                svpm_pkg::REG_COEF_A:   cfg_reg.coef_a   <= cfg_data;
                svpm_pkg::REG_COEF_B:   cfg_reg.coef_b   <= cfg_data;
                svpm_pkg::REG_COEF_C:   cfg_reg.coef_c   <= cfg_data;
                svpm_pkg::REG_COEF_D:   cfg_reg.coef_d   <= cfg_data;
                svpm_pkg::REG_COS_RHO:  cfg_reg.cos_rho  <= cfg_data[svpm_pkg::TRIG_W-1:0];
                svpm_pkg::REG_SIN_RHO:  cfg_reg.sin_rho  <= cfg_data[svpm_pkg::TRIG_W-1:0];
                svpm_pkg::REG_OFFSET_X: cfg_reg.offset_x <= cfg_data;
                svpm_pkg::REG_OFFSET_Y: cfg_reg.offset_y <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/svpm_pipe_ctrl.sv =====
// ============================================================================
// svpm_pipe_ctrl
// Valid bits and per-stage load enables; a stage moves when the output is
// ready or any stage from it up to the output is empty.
// ============================================================================
`default_nettype none

module svpm_pipe_ctrl #(
    parameter int STAGES = 17
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [STAGES-1:0]      en
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;

    always_comb
    begin
        logic all_full;
        for (int k = 0; k < STAGES; k++)
        begin
            all_full = 1'b1;
            for (int j = k; j < STAGES; j++)
            begin
                all_full = all_full & valid_reg[j];
            end
            en[k] = out_ready | ~all_full;
        end
    end

    always_comb
    begin
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/svpm_isqrt.sv =====
// ============================================================================
// svpm_isqrt
// Pipelined integer square root of the squared voltage radius, a few
// restoring steps per stage.
// ============================================================================
`default_nettype none

module svpm_isqrt (
    input  wire logic                                 clk,
    input  wire logic [svpm_pkg::ROOT_STAGES-1:0]     en,
    input  wire logic [svpm_pkg::SQ_W-1:0]            sq_in,
    output logic      [svpm_pkg::RAD_W-1:0]           root
);

    typedef struct packed {
        logic [svpm_pkg::SQ_W-1:0] rem;
        logic [svpm_pkg::SQ_W-1:0] res;
    } root_state_t;

    function automatic root_state_t root_steps(input root_state_t cur, input int top_k);
        root_state_t            st;
        logic [svpm_pkg::SQ_W:0] bit_v;
        logic [svpm_pkg::SQ_W:0] trial;
        int                     k;
        st = cur;
        for (int j = 0; j < svpm_pkg::ROOT_STEPS; j++)
        begin
            k     = top_k - j;
            bit_v = (svpm_pkg::SQ_W+1)'(1) << (2 * k);
            trial = {1'b0, st.res} + bit_v;
            if ({1'b0, st.rem} >= trial)
            begin
                st.rem = st.rem - trial[svpm_pkg::SQ_W-1:0];
                st.res = (st.res >> 1) + bit_v[svpm_pkg::SQ_W-1:0];
            end
            else
            begin
                st.res = st.res >> 1;
            end
        end
        return st;
    endfunction

    root_state_t stage_reg [svpm_pkg::ROOT_STAGES];
    root_state_t init_state;

    assign init_state.rem = sq_in;
    assign init_state.res = '0;

    for (genvar s = 0; s < svpm_pkg::ROOT_STAGES; s++)
    begin : g_stage
        if (s == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    stage_reg[s] <= root_steps(init_state, svpm_pkg::RAD_W - 1);
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    stage_reg[s] <= root_steps(stage_reg[s-1],
                                               svpm_pkg::RAD_W - 1 - svpm_pkg::ROOT_STEPS * s);
                end
            end
        end
    end

    assign root = stage_reg[svpm_pkg::ROOT_STAGES-1].res[svpm_pkg::RAD_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/svpm_horner_step.sv =====
// ============================================================================
// svpm_horner_step
// One step of the radial polynomial: acc * R, floored by the fraction bits,
// plus the next coefficient. Two stages: split products, then sum and add.
// ============================================================================
`default_nettype none

module svpm_horner_step #(
    parameter int ACC_W     = 50,
    parameter int FRAC_BITS = 15
) (
    input  wire logic                                clk,
    input  wire logic [1:0]                          en,
    input  wire logic signed [ACC_W-1:0]             acc_in,
    input  wire logic        [svpm_pkg::RAD_W-1:0]   radius_in,
    input  wire logic signed [svpm_pkg::COEF_W-1:0]  coef,
    output logic      signed [ACC_W-1:0]             acc_out,
    output logic             [svpm_pkg::RAD_W-1:0]   radius_out
);

    localparam int HI_W = ACC_W - svpm_pkg::LO_W + svpm_pkg::RAD_W + 1;
    localparam int LP_W = svpm_pkg::LO_W + svpm_pkg::RAD_W;
    localparam int P_W  = ACC_W + svpm_pkg::RAD_W + 1;

    logic        [LP_W-1:0]            lo_prod_reg;
    logic signed [HI_W-1:0]            hi_prod_reg;
    logic        [svpm_pkg::RAD_W-1:0] rad_a_reg;
    logic signed [ACC_W-1:0]           acc_reg;
    logic        [svpm_pkg::RAD_W-1:0] rad_b_reg;

    logic signed [P_W-1:0]             p_sum;
    logic signed [P_W-1:0]             p_shift;
    logic signed [ACC_W-1:0]           acc_next;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lo_prod_reg <= acc_in[svpm_pkg::LO_W-1:0] * radius_in;
            hi_prod_reg <= $signed(acc_in[ACC_W-1:svpm_pkg::LO_W]) * $signed({1'b0, radius_in});
            rad_a_reg   <= radius_in;
        end
    end

    always_comb
    begin
        p_sum    = (P_W'(hi_prod_reg) <<< svpm_pkg::LO_W)
                 + $signed({{(P_W - LP_W){1'b0}}, lo_prod_reg});
        p_shift  = p_sum >>> FRAC_BITS;
        acc_next = ACC_W'(p_shift) + ACC_W'(coef);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            acc_reg   <= acc_next;
            rad_b_reg <= rad_a_reg;
        end
    end

    assign acc_out    = acc_reg;
    assign radius_out = rad_b_reg;

endmodule

`default_nettype wire

// ===== rtl/core/svpm_scale_out.sv =====
// ============================================================================
// svpm_scale_out
// Scales one rotated coordinate by the radial factor, floors, clamps the wide
// result, adds the translation and saturates to a 32-bit position.
// ============================================================================
`default_nettype none

module svpm_scale_out #(
    parameter int ACC_W     = 50,
    parameter int FRAC_BITS = 15
) (
    input  wire logic                                clk,
    input  wire logic [4:0]                          en,
    input  wire logic signed [ACC_W-1:0]             acc_in,
    input  wire logic signed [svpm_pkg::ROT_W-1:0]   rot_in,
    input  wire logic signed [svpm_pkg::POS_W-1:0]   offset,
    output logic      signed [svpm_pkg::POS_W-1:0]   pos,
    output logic                                     clip
);

    localparam int RL_W  = 16;
    localparam int RH_W  = svpm_pkg::ROT_W - RL_W;
    localparam int AH_W  = ACC_W - svpm_pkg::LO_W;
    localparam int LL_W  = svpm_pkg::LO_W + RL_W;
    localparam int LH_W  = svpm_pkg::LO_W + 1 + RH_W;
    localparam int HL_W  = AH_W + RL_W + 1;
    localparam int HH_W  = AH_W + RH_W;
    localparam int SA_W  = HL_W + RL_W + 1;
    localparam int SB_W  = LH_W + RL_W + 1;
    localparam int PR_W  = ACC_W + svpm_pkg::ROT_W + 1;
    localparam int SHIFT = FRAC_BITS + svpm_pkg::ROT_BITS;
    localparam int CW    = svpm_pkg::CLAMP_W;

    localparam logic signed [PR_W-1:0] LIM_WIDE = PR_W'(1) <<< svpm_pkg::CLAMP_SHIFT;
    localparam logic signed [CW-1:0]   LIM_NARROW = CW'(LIM_WIDE);
    localparam logic signed [CW-1:0]   POS_MAX = CW'(32'sh7fff_ffff);
    localparam logic signed [CW-1:0]   POS_MIN = CW'($signed(32'h8000_0000));

    logic        [LL_W-1:0]  p_ll_reg;
    logic signed [LH_W-1:0]  p_lh_reg;
    logic signed [HL_W-1:0]  p_hl_reg;
    logic signed [HH_W-1:0]  p_hh_reg;
    logic signed [SA_W-1:0]  s_a_reg;
    logic signed [SB_W-1:0]  s_b_reg;
    logic signed [PR_W-1:0]  prod_reg;
    logic signed [CW-1:0]    sum_reg;
    logic signed [svpm_pkg::POS_W-1:0] pos_reg;
    logic                    clip_reg;

    logic        [svpm_pkg::LO_W-1:0] a_lo;
    logic signed [AH_W-1:0]           a_hi;
    logic        [RL_W-1:0]           r_lo;
    logic signed [RH_W-1:0]           r_hi;
    logic signed [PR_W-1:0]           q_full;
    logic signed [CW-1:0]             q_clamp;

    assign a_lo = acc_in[svpm_pkg::LO_W-1:0];
    assign a_hi = acc_in[ACC_W-1:svpm_pkg::LO_W];
    assign r_lo = rot_in[RL_W-1:0];
    assign r_hi = rot_in[svpm_pkg::ROT_W-1:RL_W];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_ll_reg <= a_lo * r_lo;
            p_lh_reg <= $signed({1'b0, a_lo}) * r_hi;
            p_hl_reg <= a_hi * $signed({1'b0, r_lo});
            p_hh_reg <= a_hi * r_hi;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s_a_reg <= (SA_W'(p_hh_reg) <<< RL_W) + SA_W'(p_hl_reg);
            s_b_reg <= (SB_W'(p_lh_reg) <<< RL_W) + $signed({{(SB_W - LL_W){1'b0}}, p_ll_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            prod_reg <= (PR_W'(s_a_reg) <<< svpm_pkg::LO_W) + PR_W'(s_b_reg);
        end
    end

    always_comb
    begin
        q_full = prod_reg >>> SHIFT;
        if (q_full > LIM_WIDE)
        begin
            q_clamp = LIM_NARROW;
        end
        else if (q_full < -LIM_WIDE)
        begin
            q_clamp = -LIM_NARROW;
        end
        else
        begin
            q_clamp = CW'(q_full);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            sum_reg <= q_clamp + CW'(offset);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            if (sum_reg > POS_MAX)
            begin
                pos_reg  <= POS_MAX[svpm_pkg::POS_W-1:0];
                clip_reg <= 1'b1;
            end
            else if (sum_reg < POS_MIN)
            begin
                pos_reg  <= POS_MIN[svpm_pkg::POS_W-1:0];
                clip_reg <= 1'b1;
            end
            else
            begin
                pos_reg  <= sum_reg[svpm_pkg::POS_W-1:0];
                clip_reg <= 1'b0;
            end
        end
    end

    assign pos  = pos_reg;
    assign clip = clip_reg;

endmodule

`default_nettype wire

// ===== rtl/core/scan_voltage_to_position_map.sv =====
// ============================================================================
// scan_voltage_to_position_map
// Maps galvo drive voltage pairs to scan positions: calibrated rotation,
// radial polynomial scaling, translation and saturation.
// ============================================================================
//
//  Channel   Direction  Handshake            Payload
//  s_axis    in         tvalid / tready      volt_x, volt_y
//  m_axis    out        tvalid / tready      pos_x, pos_y; clipped in tuser
//  cfg       in         valid / ready        register index, 32-bit word
//
//  A new word is taken every cycle unless all stages are full and m_axis
//  stalls; results pass 17 register stages (products, sums, four square
//  root stages, three two-stage polynomial steps, five output stages).
//  Reset clears the valid bits and loads the register reset values.
//  A stall on m_axis holds the unbroken run of full stages at the output;
//  the others keep filling, so s_axis stays ready until all stages are full.
//
`default_nettype none

module scan_voltage_to_position_map #(
    parameter int FRAC_BITS = 15
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [15:0] volt_x, [31:16] volt_y
    input  wire logic [31:0]                      s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [31:0] pos_x, [63:32] pos_y
    output logic [63:0]                           m_axis_tdata,
    // [0] clipped
    output logic [0:0]                            m_axis_tuser,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [svpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [svpm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int GROWTH   = (17 - FRAC_BITS > 0) ? 17 - FRAC_BITS : 0;
    localparam int ACC_W    = 35 + 3 * GROWTH;
    localparam int ST_FRONT = 0;
    localparam int ST_SUM   = 1;
    localparam int ST_ROOT  = 2;
    localparam int ST_HORN  = ST_ROOT + svpm_pkg::ROOT_STAGES;
    localparam int ST_OUT   = ST_HORN + 6;
    localparam int STAGES   = ST_OUT + 5;
    localparam int ROT_DLY  = ST_OUT - ST_ROOT;

    svpm_pkg::cfg_t      cfg;
    logic [STAGES-1:0]   en;

    logic signed [svpm_pkg::VOLT_W-1:0] volt_x;
    logic signed [svpm_pkg::VOLT_W-1:0] volt_y;

    logic signed [svpm_pkg::PROD_W-1:0] sq_x_reg;
    logic signed [svpm_pkg::PROD_W-1:0] sq_y_reg;
    logic signed [svpm_pkg::PROD_W-1:0] x_cos_reg;
    logic signed [svpm_pkg::PROD_W-1:0] y_sin_reg;
    logic signed [svpm_pkg::PROD_W-1:0] x_sin_reg;
    logic signed [svpm_pkg::PROD_W-1:0] y_cos_reg;

    logic        [svpm_pkg::SQ_W-1:0]   sq_reg;
    logic signed [svpm_pkg::ROT_W-1:0]  rot_x_reg;
    logic signed [svpm_pkg::ROT_W-1:0]  rot_y_reg;
    logic signed [svpm_pkg::ROT_W-1:0]  rot_x_dly_reg [ROT_DLY];
    logic signed [svpm_pkg::ROT_W-1:0]  rot_y_dly_reg [ROT_DLY];

    logic        [svpm_pkg::RAD_W-1:0]  radius;
    logic signed [ACC_W-1:0]            acc_a;
    logic signed [ACC_W-1:0]            acc_1;
    logic signed [ACC_W-1:0]            acc_2;
    logic signed [ACC_W-1:0]            acc_3;
    logic        [svpm_pkg::RAD_W-1:0]  radius_1;
    logic        [svpm_pkg::RAD_W-1:0]  radius_2;

    logic signed [svpm_pkg::POS_W-1:0]  pos_x;
    logic signed [svpm_pkg::POS_W-1:0]  pos_y;
    logic                               clip_x;
    logic                               clip_y;

    svpm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    svpm_pipe_ctrl #(
        .STAGES (STAGES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .en        (en)
    );

    assign volt_x = s_axis_tdata[15:0];
    assign volt_y = s_axis_tdata[31:16];

    always_ff @(posedge clk)
    begin
        if (en[ST_FRONT])
        begin
            sq_x_reg  <= volt_x * volt_x;
            sq_y_reg  <= volt_y * volt_y;
            x_cos_reg <= volt_x * cfg.cos_rho;
            y_sin_reg <= volt_y * cfg.sin_rho;
            x_sin_reg <= volt_x * cfg.sin_rho;
            y_cos_reg <= volt_y * cfg.cos_rho;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            sq_reg    <= {1'b0, sq_x_reg[svpm_pkg::SQ_W-2:0]}
                       + {1'b0, sq_y_reg[svpm_pkg::SQ_W-2:0]};
            rot_x_reg <= svpm_pkg::ROT_W'(x_cos_reg) - svpm_pkg::ROT_W'(y_sin_reg);
            rot_y_reg <= svpm_pkg::ROT_W'(x_sin_reg) + svpm_pkg::ROT_W'(y_cos_reg);
        end
    end

    for (genvar k = 0; k < ROT_DLY; k++)
    begin : g_rot_dly
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en[ST_ROOT + k])
                begin
                    rot_x_dly_reg[k] <= rot_x_reg;
                    rot_y_dly_reg[k] <= rot_y_reg;
                end
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (en[ST_ROOT + k])
                begin
                    rot_x_dly_reg[k] <= rot_x_dly_reg[k-1];
                    rot_y_dly_reg[k] <= rot_y_dly_reg[k-1];
                end
            end
        end
    end

    svpm_isqrt u_isqrt (
        .clk   (clk),
        .en    (en[ST_HORN-1:ST_ROOT]),
        .sq_in (sq_reg),
        .root  (radius)
    );

    assign acc_a = ACC_W'(cfg.coef_a);

    svpm_horner_step #(
        .ACC_W     (ACC_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_horner_b (
        .clk        (clk),
        .en         (en[ST_HORN+1:ST_HORN]),
        .acc_in     (acc_a),
        .radius_in  (radius),
        .coef       (cfg.coef_b),
        .acc_out    (acc_1),
        .radius_out (radius_1)
    );

    svpm_horner_step #(
        .ACC_W     (ACC_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_horner_c (
        .clk        (clk),
        .en         (en[ST_HORN+3:ST_HORN+2]),
        .acc_in     (acc_1),
        .radius_in  (radius_1),
        .coef       (cfg.coef_c),
        .acc_out    (acc_2),
        .radius_out (radius_2)
    );

    svpm_horner_step #(
        .ACC_W     (ACC_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_horner_d (
        .clk        (clk),
        .en         (en[ST_HORN+5:ST_HORN+4]),
        .acc_in     (acc_2),
        .radius_in  (radius_2),
        .coef       (cfg.coef_d),
        .acc_out    (acc_3),
        .radius_out ()
    );

    svpm_scale_out #(
        .ACC_W     (ACC_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_scale_x (
        .clk    (clk),
        .en     (en[STAGES-1:ST_OUT]),
        .acc_in (acc_3),
        .rot_in (rot_x_dly_reg[ROT_DLY-1]),
        .offset (cfg.offset_x),
        .pos    (pos_x),
        .clip   (clip_x)
    );

    svpm_scale_out #(
        .ACC_W     (ACC_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_scale_y (
        .clk    (clk),
        .en     (en[STAGES-1:ST_OUT]),
        .acc_in (acc_3),
        .rot_in (rot_y_dly_reg[ROT_DLY-1]),
        .offset (cfg.offset_y),
        .pos    (pos_y),
        .clip   (clip_y)
    );

    assign m_axis_tdata    = {pos_y, pos_x};
    assign m_axis_tuser[0] = clip_x | clip_y;

endmodule

`default_nettype wire
